// ===== rtl/s8fb_pkg.sv =====
// s8fb_pkg: shared types and constants of the sum8 command frame builder.
// No dependencies; imported by all RTL modules.
package s8fb_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hEB;
   localparam logic [7:0] SYNC_SECOND = 8'h90;
   localparam int unsigned JOB_MAX    = 6;   // most words one item can cause
   localparam int unsigned CNT_W      = 3;   // holds 0..JOB_MAX

   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_PAYLOAD = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] device_id;
      logic [7:0] command;
      logic [7:0] payload_length;
      logic [7:0] payload_byte;
   } req_item_type;

   // Words caused by one accepted item; word 0 goes out first.
   typedef struct packed {
      logic [JOB_MAX-1:0][7:0] bytes;
      logic [CNT_W-1:0]        count;
      logic                    has_end;   // last word is the checksum
   } job_type;

endpackage

// ===== rtl/s8fb_channels.sv =====
// s8fb_channels: valid/ready channel interfaces for the frame builder.
// Depends on nothing; used by sum8_command_frame_builder.
interface s8fb_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] device_id;
   logic [7:0] command;
   logic [7:0] payload_length;
   logic [7:0] payload_byte;

   modport source (output valid, action, device_id, command, payload_length,
                   payload_byte, input ready);
   modport sink   (input valid, action, device_id, command, payload_length,
                   payload_byte, output ready);
endinterface

interface s8fb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== rtl/s8fb_framer.sv =====
// s8fb_framer: frame state (bytes left, running sum, in frame) and the
// words each accepted item causes. Depends on s8fb_pkg.
module s8fb_framer
   import s8fb_pkg::*;
#(
   parameter int MAX_PAYLOAD = 254
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   output job_type      job
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic       in_frame_ff, in_frame_in;

   logic [7:0] len_sat, len_byte, hdr_sum, pay_sum, left_dec;

   always_comb begin
      len_sat  = (item.payload_length > MAX_LEN) ? MAX_LEN : item.payload_length;
      len_byte = len_sat + 8'd1;
      hdr_sum  = item.device_id + len_byte + item.command;
      pay_sum  = running_sum_ff + item.payload_byte;
      left_dec = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : bytes_left_ff;

      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      in_frame_in    = in_frame_ff;
      job.bytes      = '0;
      job.count      = '0;
      job.has_end    = 1'b0;

      case (item.action)
         ACT_START: begin
            job.bytes[0]   = SYNC_FIRST;
            job.bytes[1]   = SYNC_SECOND;
            job.bytes[2]   = item.device_id;
            job.bytes[3]   = len_byte;
            job.bytes[4]   = item.command;
            job.bytes[5]   = hdr_sum;
            running_sum_in = hdr_sum;
            bytes_left_in  = len_sat;
            if (len_sat == 8'd0) begin
               job.count   = CNT_W'(6);
               job.has_end = 1'b1;
               in_frame_in = 1'b0;
            end else begin
               job.count   = CNT_W'(5);
               in_frame_in = 1'b1;
            end
         end
         ACT_PAYLOAD: begin
            if (in_frame_ff) begin
               job.bytes[0]   = item.payload_byte;
               job.bytes[1]   = pay_sum;
               running_sum_in = pay_sum;
               bytes_left_in  = left_dec;
               if (left_dec == 8'd0) begin
                  job.count   = CNT_W'(2);
                  job.has_end = 1'b1;
                  in_frame_in = 1'b0;
               end else begin
                  job.count = CNT_W'(1);
               end
            end
         end
         default: begin
            job.count = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         running_sum_ff <= '0;
         in_frame_ff    <= 1'b0;
      end else if (accept) begin
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
         in_frame_ff    <= in_frame_in;
      end
   end

   // An open frame always expects at least one more payload word.
   a_open_has_left: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> bytes_left_ff != 8'd0)
      else $error("open frame with no bytes left");

   // Once idle, no payload count lingers.
   a_idle_no_left: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> bytes_left_ff == 8'd0)
      else $error("idle with bytes left");

   // A payload word outside a frame leaves the state untouched.
   a_stray_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && item.action == ACT_PAYLOAD && !in_frame_ff) |=>
         !in_frame_ff && $stable(running_sum_ff))
      else $error("stray payload changed state");

endmodule

// ===== rtl/s8fb_serializer.sv =====
// s8fb_serializer: result register holding the words of one item and
// shifting them out one per handshake. Depends on s8fb_pkg.
module s8fb_serializer
   import s8fb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  job_type    job,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_end
);

   logic [JOB_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    has_end_ff, has_end_in;
   logic                    take;

   assign out_valid = (count_ff != '0);
   assign take      = out_valid && out_ready;
   assign can_load  = (count_ff == '0) || (count_ff == CNT_W'(1) && out_ready);
   assign out_byte  = bytes_ff[0];
   assign out_end   = has_end_ff && (count_ff == CNT_W'(1));

   always_comb begin
      bytes_in   = bytes_ff;
      count_in   = count_ff;
      has_end_in = has_end_ff;
      if (load) begin
         bytes_in   = job.bytes;
         count_in   = job.count;
         has_end_in = job.has_end;
      end else if (take) begin
         bytes_in = {8'h00, bytes_ff[JOB_MAX-1:1]};
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         has_end_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         has_end_ff <= has_end_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(JOB_MAX))
      else $error("word count out of range");

   // A load never overwrites words still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == '0) || (count_ff == CNT_W'(1) && take))
      else $error("load over pending words");

   // A stall with several words queued keeps the count.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_W'(1) && !out_ready) |=> $stable(count_ff))
      else $error("count moved during stall");

endmodule

// ===== rtl/sum8_command_frame_builder.sv =====
// sum8_command_frame_builder: top level of the sum8 command frame builder.
// Depends on s8fb_pkg, s8fb_channels, s8fb_framer, s8fb_serializer.
//
// Usage:
//   req_if carries one item per handshake: action 0 starts a frame (device_id,
//   command, payload_length), action 1 carries one payload_byte. rsp_if
//   carries the frame one word per handshake: EB, 90, id, length+1, command,
//   the payload words, then the sum8 checksum with frame_end high.
//   Lengths above MAX_PAYLOAD saturate. Payload items outside a frame are
//   taken and dropped. A start inside a frame abandons the open frame.
// Output: the first word of an item is on rsp_if in the cycle after the item
//   is accepted, from the result register.
// Throughput while rsp_if.ready is high: one output word per cycle. A start
//   item occupies the result register for 5 words (6 with a zero length), a
//   payload item for 1 word (2 on the last one); req_if.ready rises again in
//   the cycle its last word is taken, so a payload stream runs at one item per
//   cycle, and start items are bound by the single output byte port.
// Reset: synchronous, active high; idle, no frame open, result register
//   empty; req_if.ready is held low while reset is high.
// Stall: while rsp_if.ready is low the pending word holds and req_if.ready
//   stays low once the result register holds words that cannot drain.
module sum8_command_frame_builder
   import s8fb_pkg::*;
#(
   parameter int MAX_PAYLOAD = 254
) (
   input logic        clock,
   input logic        reset,
   s8fb_req_if.sink   req_if,
   s8fb_rsp_if.source rsp_if
);

   req_item_type item;
   job_type      job;
   logic         can_load;
   logic         accept;

   assign item.action         = req_if.action;
   assign item.device_id      = req_if.device_id;
   assign item.command        = req_if.command;
   assign item.payload_length = req_if.payload_length;
   assign item.payload_byte   = req_if.payload_byte;

   // Accept whenever the result register is empty or drains this cycle.
   assign req_if.ready = can_load && !reset;
   assign accept       = req_if.valid && req_if.ready;

   s8fb_framer #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_framer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .job    (job)
   );

   s8fb_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .job       (job),
      .can_load  (can_load),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_byte  (rsp_if.frame_byte),
      .out_end   (rsp_if.frame_end)
   );

endmodule
